### rtl/whps_pkg.sv
// Shared constants, command and status types of the WAV header skipping sampler.
`default_nettype none
package whps_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int CHUNK_BYTES  = 8;
    localparam int POS_W        = 4;
    localparam int REPLAY_W     = 3;

    localparam logic [POS_W-1:0]    HDR_LAST     = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0]    CHUNK_LAST   = POS_W'(CHUNK_BYTES - 1);
    localparam logic [REPLAY_W-1:0] REPLAY_LAST  = REPLAY_W'(HEADER_BYTES / 2 - 1);

    localparam logic [7:0]  CH_R = 8'h52;
    localparam logic [7:0]  CH_I = 8'h49;
    localparam logic [7:0]  CH_F = 8'h46;
    localparam logic [7:0]  CH_W = 8'h57;
    localparam logic [7:0]  CH_A = 8'h41;
    localparam logic [7:0]  CH_V = 8'h56;
    localparam logic [7:0]  CH_E = 8'h45;
    localparam logic [31:0] TAG_DATA = 32'h61746164;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_HEADER,
        OP_CHUNK,
        OP_SKIP,
        OP_AUDIO,
        OP_REPLAY
    } op_t;

    typedef struct packed {
        logic fire;
        op_t  op;
        logic clear;
        logic replay_last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic hdr_done;
        logic hdr_is_wav;
        logic chunk_done;
        logic tag_is_data;
        logic size_nonzero;
        logic skip_last;
    } status_t;

endpackage
`default_nettype wire

### rtl/whps_dp.sv
// Datapath: header shift line, chunk tag and size registers, sample pairing and output register.
`default_nettype none
module whps_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       data_byte,
    input  wire whps_pkg::cmd_t   cmd,
    output whps_pkg::status_t     status,
    output logic                  sample_valid,
    input  wire logic             sample_ready,
    output logic signed [15:0]    sample,
    output logic                  is_wav,
    output logic                  last_in_run
);

    logic [7:0]                 hdr_reg  [whps_pkg::HEADER_BYTES];
    logic [7:0]                 hdr_next [whps_pkg::HEADER_BYTES];
    logic [whps_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [31:0]                tag_reg, tag_next;
    logic [31:0]                skip_reg, skip_next;
    logic [7:0]                 pend_reg, pend_next;
    logic                       held_reg, held_next;
    logic                       wav_reg, wav_next;
    logic                       out_valid_reg, out_valid_next;
    logic [15:0]                sample_reg, sample_next;
    logic                       is_wav_reg, is_wav_next;
    logic                       last_reg, last_next;
    logic                       load;
    logic                       run;

    assign run = cmd.fire || (cmd.op == whps_pkg::OP_REPLAY);

    // Status is taken from the registers, sample_ready and the byte on offer in this cycle.
    always_comb
    begin
        status.out_free     = !out_valid_reg || sample_ready;
        status.hdr_done     = (pos_reg == whps_pkg::HDR_LAST);
        status.hdr_is_wav   = (hdr_reg[1] == whps_pkg::CH_R) && (hdr_reg[2] == whps_pkg::CH_I) &&
                              (hdr_reg[3] == whps_pkg::CH_F) && (hdr_reg[4] == whps_pkg::CH_F) &&
                              (hdr_reg[9] == whps_pkg::CH_W) && (hdr_reg[10] == whps_pkg::CH_A) &&
                              (hdr_reg[11] == whps_pkg::CH_V) && (data_byte == whps_pkg::CH_E);
        status.chunk_done   = (pos_reg == whps_pkg::CHUNK_LAST);
        status.tag_is_data  = (tag_reg == whps_pkg::TAG_DATA);
        status.size_nonzero = ({data_byte, skip_reg[23:0]} != 32'd0);
        status.skip_last    = (skip_reg == 32'd1);
    end

    always_comb
    begin
        hdr_next       = hdr_reg;
        pos_next       = pos_reg;
        tag_next       = tag_reg;
        skip_next      = skip_reg;
        pend_next      = pend_reg;
        held_next      = held_reg;
        wav_next       = wav_reg;
        load           = 1'b0;
        sample_next    = sample_reg;
        is_wav_next    = is_wav_reg;
        last_next      = last_reg;
        if (run)
        begin
            case (cmd.op)
                whps_pkg::OP_HEADER:
                begin
                    // The header enters at the top and moves down, so byte 0 ends at entry 0.
                    for (int i = 0; i < whps_pkg::HEADER_BYTES - 1; i++)
                    begin
                        hdr_next[i] = hdr_reg[i+1];
                    end
                    hdr_next[whps_pkg::HEADER_BYTES-1] = data_byte;
                    if (status.hdr_done)
                    begin
                        pos_next  = '0;
                        wav_next  = status.hdr_is_wav;
                        tag_next  = 32'd0;
                        skip_next = 32'd0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                whps_pkg::OP_CHUNK:
                begin
                    for (int l = 0; l < 4; l++)
                    begin
                        if (pos_reg[1:0] == 2'(l))
                        begin
                            if (pos_reg[2])
                            begin
                                skip_next[8*l +: 8] = data_byte;
                            end
                            else
                            begin
                                tag_next[8*l +: 8] = data_byte;
                            end
                        end
                    end
                    if (status.chunk_done)
                    begin
                        pos_next = '0;
                        tag_next = 32'd0;
                        if (status.tag_is_data || !status.size_nonzero)
                        begin
                            skip_next = 32'd0;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                whps_pkg::OP_SKIP:
                begin
                    skip_next = skip_reg - 32'd1;
                end
                whps_pkg::OP_AUDIO:
                begin
                    if (held_reg)
                    begin
                        load        = 1'b1;
                        sample_next = {data_byte, pend_reg};
                        is_wav_next = wav_reg;
                        last_next   = 1'b1;
                        held_next   = 1'b0;
                    end
                    else
                    begin
                        pend_next = data_byte;
                        held_next = 1'b1;
                    end
                end
                whps_pkg::OP_REPLAY:
                begin
                    load        = 1'b1;
                    sample_next = {hdr_reg[1], hdr_reg[0]};
                    is_wav_next = wav_reg;
                    last_next   = cmd.replay_last;
                    for (int i = 0; i < whps_pkg::HEADER_BYTES - 2; i++)
                    begin
                        hdr_next[i] = hdr_reg[i+2];
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.clear)
        begin
            pos_next  = '0;
            tag_next  = 32'd0;
            skip_next = 32'd0;
            pend_next = 8'd0;
            held_next = 1'b0;
            wav_next  = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (sample_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            tag_reg       <= 32'd0;
            skip_reg      <= 32'd0;
            pend_reg      <= 8'd0;
            held_reg      <= 1'b0;
            wav_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            tag_reg       <= tag_next;
            skip_reg      <= skip_next;
            pend_reg      <= pend_next;
            held_reg      <= held_next;
            wav_reg       <= wav_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg    <= hdr_next;
        sample_reg <= sample_next;
        is_wav_reg <= is_wav_next;
        last_reg   <= last_next;
    end

    assign sample_valid = out_valid_reg;
    assign sample       = $signed(sample_reg);
    assign is_wav       = is_wav_reg;
    assign last_in_run  = last_reg;

endmodule
`default_nettype wire

### rtl/whps_ctrl.sv
// Controller: file phase state machine and raw header replay sequencing.
`default_nettype none
module whps_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_ready,
    input  wire logic              end_of_file,
    input  wire whps_pkg::status_t status,
    output whps_pkg::cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_CHUNK,
        ST_SKIP,
        ST_AUDIO,
        ST_REPLAY
    } state_t;

    state_t                        state_reg, state_next;
    logic [whps_pkg::REPLAY_W-1:0] cnt_reg, cnt_next;
    logic                          eof_pend_reg, eof_pend_next;
    logic                          fire;

    // No request is taken while the raw header is replayed or the output is full.
    assign byte_ready = (state_reg != ST_REPLAY) && status.out_free;
    assign fire       = byte_valid && byte_ready;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        eof_pend_next   = eof_pend_reg;
        cmd.fire        = fire;
        cmd.op          = whps_pkg::OP_NONE;
        cmd.clear       = fire && end_of_file;
        cmd.replay_last = (cnt_reg == whps_pkg::REPLAY_LAST);
        case (state_reg)
            ST_HEADER:
            begin
                if (fire)
                begin
                    cmd.op = whps_pkg::OP_HEADER;
                    if (status.hdr_done && !status.hdr_is_wav)
                    begin
                        state_next    = ST_REPLAY;
                        cnt_next      = '0;
                        eof_pend_next = end_of_file;
                    end
                    else if (status.hdr_done && !end_of_file)
                    begin
                        state_next = ST_CHUNK;
                    end
                end
            end
            ST_CHUNK:
            begin
                if (fire)
                begin
                    cmd.op = whps_pkg::OP_CHUNK;
                    if (end_of_file)
                    begin
                        state_next = ST_HEADER;
                    end
                    else if (status.chunk_done && status.tag_is_data)
                    begin
                        state_next = ST_AUDIO;
                    end
                    else if (status.chunk_done && status.size_nonzero)
                    begin
                        state_next = ST_SKIP;
                    end
                end
            end
            ST_SKIP:
            begin
                if (fire)
                begin
                    cmd.op = whps_pkg::OP_SKIP;
                    if (end_of_file)
                    begin
                        state_next = ST_HEADER;
                    end
                    else if (status.skip_last)
                    begin
                        state_next = ST_CHUNK;
                    end
                end
            end
            ST_AUDIO:
            begin
                if (fire)
                begin
                    cmd.op = whps_pkg::OP_AUDIO;
                    if (end_of_file)
                    begin
                        state_next = ST_HEADER;
                    end
                end
            end
            ST_REPLAY:
            begin
                if (status.out_free)
                begin
                    cmd.op   = whps_pkg::OP_REPLAY;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == whps_pkg::REPLAY_LAST)
                    begin
                        state_next = eof_pend_reg ? ST_HEADER : ST_AUDIO;
                    end
                end
            end
            default:
            begin
                state_next = ST_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_HEADER;
            cnt_reg      <= '0;
            eof_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            eof_pend_reg <= eof_pend_next;
        end
    end

    a_replay_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REPLAY |-> cnt_reg <= whps_pkg::REPLAY_LAST)
        else $error("replay counter ran past the last header sample");

    a_replay_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPLAY && status.out_free && cnt_reg == whps_pkg::REPLAY_LAST)
        |=> state_reg != ST_REPLAY)
        else $error("replay did not end after six samples");

    a_fire_free: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> status.out_free && state_reg != ST_REPLAY)
        else $error("request taken while output full or replaying");

    a_eof_home: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && end_of_file && state_reg != ST_HEADER) |=> state_reg == ST_HEADER)
        else $error("end of file did not return to header collection");

endmodule
`default_nettype wire

### rtl/wav_header_skip_pcm_sampler.sv
// Top level of the WAV header skipping PCM sampler: controller and datapath.
// A sample is on the output register in the cycle after the byte that completes it.
// Throughput: one byte per cycle while the output is drained; header and skipped bytes too.
// A raw (non-WAV) header is replayed as six samples, one per output register load while
// the output is free, during which no byte is taken.
// Reset clears all control state at once; the header shift line needs no clearing.
`default_nettype none
module wav_header_skip_pcm_sampler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_file,
    output logic             sample_valid,
    input  wire logic        sample_ready,
    output logic signed [15:0] sample,
    output logic             is_wav,
    output logic             last_in_run
);

    whps_pkg::cmd_t    cmd;
    whps_pkg::status_t status;

    whps_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .end_of_file (end_of_file),
        .status      (status),
        .cmd         (cmd)
    );

    whps_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .cmd          (cmd),
        .status       (status),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .is_wav       (is_wav),
        .last_in_run  (last_in_run)
    );

endmodule
`default_nettype wire
